// File: design/bur_pkg.sv
package bur_pkg;

	// Ring depths
	localparam int TX_DEPTH_DEF = 128;
	localparam int RX_DEPTH_DEF = 128;

	// Field widths
	localparam int FUNC_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int NEED_W  = 8;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 16;

	// Function codes of an input item
	localparam logic [FUNC_W-1:0] FN_SEND  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_TXRDY = 3'd1;
	localparam logic [FUNC_W-1:0] FN_RECV  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SPACE = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
	localparam logic [STAT_W-1:0] ST_LOST    = 2'd2;
	localparam logic [STAT_W-1:0] ST_RX_ERR  = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;   // zero one receive slot
		logic accept;  // capture item, issue ring reads
		logic exec;    // update state, load result register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_done;  // last receive slot being cleared
		logic out_hold;    // result register full and not taken
	} dp_stat_t;

endpackage

// File: design/bur_cmd_if.sv
interface bur_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [bur_pkg::FUNC_W-1:0]       func;
	logic [bur_pkg::BYTE_W-1:0]       byte_in;
	logic [bur_pkg::NEED_W-1:0]       need_len;
	logic                             overrun_flag;
	logic                             noise_flag;
	logic                             framing_flag;

	modport source (
		output valid, func, byte_in, need_len, overrun_flag, noise_flag, framing_flag,
		input  ready
	);
	modport sink (
		input  valid, func, byte_in, need_len, overrun_flag, noise_flag, framing_flag,
		output ready
	);
endinterface

// File: design/bur_rsp_if.sv
interface bur_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             line_valid;
	logic [bur_pkg::BYTE_W-1:0]       line_byte;
	logic [bur_pkg::BYTE_W-1:0]       read_byte;
	logic                             read_was_empty;
	logic                             space_ok;
	logic [bur_pkg::STAT_W-1:0]       status;
	logic                             tx_busy;
	logic [bur_pkg::COUNT_W-1:0]      overrun_total;
	logic [bur_pkg::COUNT_W-1:0]      noise_total;
	logic [bur_pkg::COUNT_W-1:0]      framing_total;

	modport source (
		output valid, line_valid, line_byte, read_byte, read_was_empty, space_ok,
		       status, tx_busy, overrun_total, noise_total, framing_total,
		input  ready
	);
	modport sink (
		input  valid, line_valid, line_byte, read_byte, read_was_empty, space_ok,
		       status, tx_busy, overrun_total, noise_total, framing_total,
		output ready
	);
endinterface

// File: design/bur_ctrl.sv
module bur_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bur_pkg::dp_stat_t   stat,
	output bur_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Take an item only when idle and the result register is free this cycle
	assign in_ready = (state_q == S_IDLE) && !stat.out_hold;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

endmodule

// File: design/bur_datapath.sv
module bur_datapath #(
	parameter int TX_DEPTH = bur_pkg::TX_DEPTH_DEF,
	parameter int RX_DEPTH = bur_pkg::RX_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bur_pkg::ctrl_cmd_t            cmd,
	output bur_pkg::dp_stat_t             stat,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic [bur_pkg::FUNC_W-1:0]    func,
	input  logic [bur_pkg::BYTE_W-1:0]    byte_in,
	input  logic [bur_pkg::NEED_W-1:0]    need_len,
	input  logic                          overrun_flag,
	input  logic                          noise_flag,
	input  logic                          framing_flag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_valid,
	output logic [bur_pkg::BYTE_W-1:0]    line_byte,
	output logic [bur_pkg::BYTE_W-1:0]    read_byte,
	output logic                          read_was_empty,
	output logic                          space_ok,
	output logic [bur_pkg::STAT_W-1:0]    status,
	output logic                          tx_busy,
	output logic [bur_pkg::COUNT_W-1:0]   overrun_total,
	output logic [bur_pkg::COUNT_W-1:0]   noise_total,
	output logic [bur_pkg::COUNT_W-1:0]   framing_total
);

	localparam int TPW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int RPW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int CW  = (TPW + 1 > bur_pkg::NEED_W) ? TPW + 1 : bur_pkg::NEED_W + 1;
	localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
	localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
	localparam logic [TPW:0]   TX_SIZE = (TPW + 1)'(TX_DEPTH);

	// Ring memories
	logic [bur_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];
	logic [bur_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];

	// Ring pointers, flags, counters, config
	logic [TPW-1:0] tx_head_q, tx_tail_q;
	logic [RPW-1:0] rx_head_q, rx_tail_q, clr_q;
	logic           running_q, rx_en_q;
	logic [bur_pkg::COUNT_W-1:0] ovr_cnt_q, nse_cnt_q, frm_cnt_q;

	// Captured item and ring read data
	logic [bur_pkg::FUNC_W-1:0] func_s1;
	logic [bur_pkg::BYTE_W-1:0] byte_s1, tx_rd_s1, rx_rd_s1;
	logic [bur_pkg::NEED_W-1:0] need_s1;
	logic                       ovr_s1, nse_s1, frm_s1;

	// Result register
	logic                          out_valid_q;
	logic                          lv_q, empty_q, sok_q, busy_q;
	logic [bur_pkg::BYTE_W-1:0]    lb_q, rb_q;
	logic [bur_pkg::STAT_W-1:0]    st_q;
	logic [bur_pkg::COUNT_W-1:0]   ovr_out_q, nse_out_q, frm_out_q;

	// Next-state values of the execute step
	logic [TPW-1:0] tx_head_inc, tx_tail_inc, tx_head_d, tx_tail_d;
	logic [RPW-1:0] rx_head_inc, rx_tail_inc, rx_head_d, rx_tail_d;
	logic           running_d, tx_we, rx_we;
	logic [bur_pkg::COUNT_W-1:0] ovr_cnt_d, nse_cnt_d, frm_cnt_d;
	logic                        lv_d, empty_d, sok_d;
	logic [bur_pkg::BYTE_W-1:0]  lb_d, rb_d;
	logic [bur_pkg::STAT_W-1:0]  st_d;
	logic [TPW:0]                tx_free;

	assign tx_head_inc = (tx_head_q == TX_LAST) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_inc = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + 1'b1;
	assign rx_head_inc = (rx_head_q == RX_LAST) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_inc = (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + 1'b1;

	// Free transmit slots, one slot always kept unused
	always_comb begin
		if (tx_tail_q > tx_head_q)
			tx_free = {1'b0, tx_tail_q} - {1'b0, tx_head_q} - 1'b1;
		else
			tx_free = {1'b0, tx_tail_q} + TX_SIZE - {1'b0, tx_head_q} - 1'b1;
	end

	// Execute step for the captured item
	always_comb begin
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		running_d = running_q;
		ovr_cnt_d = ovr_cnt_q;
		nse_cnt_d = nse_cnt_q;
		frm_cnt_d = frm_cnt_q;
		tx_we     = 1'b0;
		rx_we     = 1'b0;
		lv_d      = 1'b0;
		lb_d      = '0;
		rb_d      = '0;
		empty_d   = 1'b0;
		sok_d     = 1'b0;
		st_d      = bur_pkg::ST_OK;
		unique case (func_s1)
			bur_pkg::FN_SEND: begin
				if (tx_head_inc == tx_tail_q) begin
					st_d = bur_pkg::ST_DROPPED;
				end else if (running_q) begin
					tx_we     = 1'b1;
					tx_head_d = tx_head_inc;
				end else begin
					// idle transmitter: byte goes straight to the line
					running_d = 1'b1;
					lv_d      = 1'b1;
					lb_d      = byte_s1;
				end
			end
			bur_pkg::FN_TXRDY: begin
				if (tx_head_q != tx_tail_q) begin
					lv_d      = 1'b1;
					lb_d      = tx_rd_s1;
					tx_tail_d = tx_tail_inc;
				end else begin
					running_d = 1'b0;
				end
			end
			bur_pkg::FN_RECV: begin
				if (rx_en_q) begin
					if (!ovr_s1 && !nse_s1 && !frm_s1) begin
						// full ring: slot overwritten, head stays
						rx_we = 1'b1;
						if (rx_head_inc != rx_tail_q) rx_head_d = rx_head_inc;
						else                          st_d      = bur_pkg::ST_LOST;
					end else begin
						if (ovr_s1) ovr_cnt_d = ovr_cnt_q + 1'b1;
						if (nse_s1) nse_cnt_d = nse_cnt_q + 1'b1;
						if (frm_s1) frm_cnt_d = frm_cnt_q + 1'b1;
						st_d = bur_pkg::ST_RX_ERR;
					end
				end
			end
			bur_pkg::FN_READ: begin
				empty_d   = (rx_head_q == rx_tail_q);
				rb_d      = rx_rd_s1;
				rx_tail_d = rx_tail_inc;
			end
			bur_pkg::FN_SPACE: begin
				sok_d = (CW'(tx_free) >= CW'(need_s1));
			end
			default: ;
		endcase
	end

	// Transmit ring memory, write on execute, read on accept
	always_ff @(posedge clk) begin
		if (cmd.exec && tx_we) tx_mem[tx_head_q] <= byte_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) tx_rd_s1 <= tx_mem[tx_tail_q];
	end

	// Receive ring memory, zeroed by the clear sweep after reset
	always_ff @(posedge clk) begin
		if (cmd.clear)              rx_mem[clr_q]     <= '0;
		else if (cmd.exec && rx_we) rx_mem[rx_head_q] <= byte_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) rx_rd_s1 <= rx_mem[rx_tail_q];
	end

	// Clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        clr_q <= '0;
		else if (cmd.clear) clr_q <= (clr_q == RX_LAST) ? '0 : clr_q + 1'b1;
	end

	assign stat.clear_done = cmd.clear && (clr_q == RX_LAST);
	assign stat.out_hold   = out_valid_q && !out_ready;

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_s1 <= func;
			byte_s1 <= byte_in;
			need_s1 <= need_len;
			ovr_s1  <= overrun_flag;
			nse_s1  <= noise_flag;
			frm_s1  <= framing_flag;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q <= '0;
			tx_tail_q <= '0;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			running_q <= 1'b0;
			ovr_cnt_q <= '0;
			nse_cnt_q <= '0;
			frm_cnt_q <= '0;
		end else if (cmd.exec) begin
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			running_q <= running_d;
			ovr_cnt_q <= ovr_cnt_d;
			nse_cnt_q <= nse_cnt_d;
			frm_cnt_q <= frm_cnt_d;
		end
	end

	// Receive enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     rx_en_q <= 1'b1;
		else if (cfg_we) rx_en_q <= cfg_wdata;
	end

	// Result valid: set on execute, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)               out_valid_q <= 1'b0;
		else if (cmd.exec)         out_valid_q <= 1'b1;
		else if (out_ready)        out_valid_q <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			lv_q      <= lv_d;
			lb_q      <= lb_d;
			rb_q      <= rb_d;
			empty_q   <= empty_d;
			sok_q     <= sok_d;
			st_q      <= st_d;
			busy_q    <= running_d;
			ovr_out_q <= ovr_cnt_d;
			nse_out_q <= nse_cnt_d;
			frm_out_q <= frm_cnt_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign line_valid     = lv_q;
	assign line_byte      = lb_q;
	assign read_byte      = rb_q;
	assign read_was_empty = empty_q;
	assign space_ok       = sok_q;
	assign status         = st_q;
	assign tx_busy        = busy_q;
	assign overrun_total  = ovr_out_q;
	assign noise_total    = nse_out_q;
	assign framing_total  = frm_out_q;

endmodule

// File: design/buffered_uart_ring_queues.sv
// An item is captured at its input transfer and its result register loads in
// the execute state; no new item is taken before then. The ring read is
// registered at the input transfer and the state update happens in the
// following cycle. A result that is not taken holds off the next input transfer.
// Reset: pointers, busy flag and error counters clear; the receive ring is
// zeroed by a sweep over every slot, during which no item is taken.
module buffered_uart_ring_queues #(
	parameter int TX_DEPTH = bur_pkg::TX_DEPTH_DEF,
	parameter int RX_DEPTH = bur_pkg::RX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	bur_cmd_if.sink    cmd,
	bur_rsp_if.source  rsp
);

	bur_pkg::ctrl_cmd_t ctl;
	bur_pkg::dp_stat_t  stat;

	// Sequencer
	bur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	// Rings, pointers, counters and result register
	bur_datapath #(
		.TX_DEPTH (TX_DEPTH),
		.RX_DEPTH (RX_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.func           (cmd.func),
		.byte_in        (cmd.byte_in),
		.need_len       (cmd.need_len),
		.overrun_flag   (cmd.overrun_flag),
		.noise_flag     (cmd.noise_flag),
		.framing_flag   (cmd.framing_flag),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.line_valid     (rsp.line_valid),
		.line_byte      (rsp.line_byte),
		.read_byte      (rsp.read_byte),
		.read_was_empty (rsp.read_was_empty),
		.space_ok       (rsp.space_ok),
		.status         (rsp.status),
		.tx_busy        (rsp.tx_busy),
		.overrun_total  (rsp.overrun_total),
		.noise_total    (rsp.noise_total),
		.framing_total  (rsp.framing_total)
	);

endmodule

// File: dv/buffered_uart_ring_queues_tb.sv
module buffered_uart_ring_queues_tb;
	import bur_pkg::*;

	localparam int TX_AW = $clog2(TX_DEPTH_DEF);
	localparam int RX_AW = $clog2(RX_DEPTH_DEF);

	// Codes that select no function
	localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 3'd5;
	localparam logic [FUNC_W-1:0] FN_LAST_UNUSED  = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] byte_in;
		logic [NEED_W-1:0] need_len;
		logic              overrun_flag;
		logic              noise_flag;
		logic              framing_flag;
	} uart_cmd_t;

	typedef struct packed {
		logic               line_valid;
		logic [BYTE_W-1:0]  line_byte;
		logic [BYTE_W-1:0]  read_byte;
		logic               read_was_empty;
		logic               space_ok;
		logic [STAT_W-1:0]  status;
		logic               tx_busy;
		logic [COUNT_W-1:0] overrun_total;
		logic [COUNT_W-1:0] noise_total;
		logic [COUNT_W-1:0] framing_total;
	} uart_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	bur_cmd_if cmd_bus ();
	bur_rsp_if rsp_bus ();

	buffered_uart_ring_queues u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus)
	);

	// Shadow copy of the UART state
	logic [BYTE_W-1:0]  tx_ring [TX_DEPTH_DEF];
	logic [BYTE_W-1:0]  rx_ring [RX_DEPTH_DEF];
	logic [TX_AW-1:0]   tx_wr, tx_rd;
	logic [RX_AW-1:0]   rx_wr, rx_rd;
	logic               tx_active;
	logic               rx_en;
	logic [COUNT_W-1:0] overrun_cnt, noise_cnt, framing_cnt;

	uart_result_t pending_results[$];
	int           mismatches;
	bit           no_gaps;
	bit           no_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected result of one item; updates the shadow state
	function automatic uart_result_t uart_predict(uart_cmd_t c);
		uart_result_t     r;
		logic [TX_AW-1:0] tx_nxt, room;
		logic [RX_AW-1:0] rx_nxt;
		r = '0;
		case (c.func)
			FN_SEND: begin
				tx_nxt = tx_wr + 1'b1;
				if (tx_nxt == tx_rd) begin
					r.status = ST_DROPPED;
				end else if (tx_active) begin
					tx_ring[tx_wr] = c.byte_in;
					tx_wr = tx_nxt;
				end else begin
					// idle transmitter takes the byte directly
					tx_active = 1'b1;
					r.line_valid = 1'b1;
					r.line_byte = c.byte_in;
				end
			end
			FN_TXRDY: begin
				if (tx_wr != tx_rd) begin
					r.line_valid = 1'b1;
					r.line_byte = tx_ring[tx_rd];
					tx_rd = tx_rd + 1'b1;
				end else begin
					tx_active = 1'b0;
				end
			end
			FN_RECV: begin
				if (rx_en) begin
					if (!(c.overrun_flag || c.noise_flag || c.framing_flag)) begin
						rx_nxt = rx_wr + 1'b1;
						rx_ring[rx_wr] = c.byte_in;
						if (rx_nxt != rx_rd)
							rx_wr = rx_nxt;
						else
							r.status = ST_LOST;
					end else begin
						if (c.overrun_flag) overrun_cnt = overrun_cnt + 1'b1;
						if (c.noise_flag)   noise_cnt = noise_cnt + 1'b1;
						if (c.framing_flag) framing_cnt = framing_cnt + 1'b1;
						r.status = ST_RX_ERR;
					end
				end
			end
			FN_READ: begin
				// no empty guard: tail moves regardless
				r.read_was_empty = (rx_wr == rx_rd);
				r.read_byte = rx_ring[rx_rd];
				rx_rd = rx_rd + 1'b1;
			end
			FN_SPACE: begin
				room = tx_rd - tx_wr - 1'b1;
				r.space_ok = ({1'b0, room} >= c.need_len);
			end
			default: ;
		endcase
		r.tx_busy = tx_active;
		r.overrun_total = overrun_cnt;
		r.noise_total = noise_cnt;
		r.framing_total = framing_cnt;
		return r;
	endfunction

	function automatic uart_cmd_t make_cmd(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
			logic [NEED_W-1:0] n, logic [2:0] flags);
		uart_cmd_t c;
		c.func = f;
		c.byte_in = b;
		c.need_len = n;
		{c.overrun_flag, c.noise_flag, c.framing_flag} = flags;
		return c;
	endfunction

	function automatic uart_cmd_t random_cmd(logic [FUNC_W-1:0] f);
		return make_cmd(f, BYTE_W'($urandom_range(0, 255)), NEED_W'($urandom_range(0, 255)),
			3'($urandom_range(0, 7)));
	endfunction

	// One command transfer; expectation is queued at the accepting edge
	task automatic send_item(uart_cmd_t c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			cmd_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_bus.valid = 1'b1;
		cmd_bus.func = c.func;
		cmd_bus.byte_in = c.byte_in;
		cmd_bus.need_len = c.need_len;
		cmd_bus.overrun_flag = c.overrun_flag;
		cmd_bus.noise_flag = c.noise_flag;
		cmd_bus.framing_flag = c.framing_flag;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		pending_results.push_back(uart_predict(c));
	endtask

	// Stop sending and let every result drain out
	task automatic settle_idle();
		@(negedge clk);
		cmd_bus.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rx_enable(logic v);
		settle_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		rx_en = v;
	endtask

	task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Response side: random stalls, field-by-field compare on each transfer
	initial begin : rsp_side
		int           stall;
		uart_result_t got, want;
		rsp_bus.ready = 1'b0;
		forever begin
			stall = no_stalls ? 0 : $urandom_range(0, 7);
			repeat (stall) begin
				@(negedge clk);
				rsp_bus.ready = 1'b0;
			end
			@(negedge clk);
			rsp_bus.ready = 1'b1;
			do @(posedge clk); while (rsp_bus.valid !== 1'b1);
			got.line_valid = rsp_bus.line_valid;
			got.line_byte = rsp_bus.line_byte;
			got.read_byte = rsp_bus.read_byte;
			got.read_was_empty = rsp_bus.read_was_empty;
			got.space_ok = rsp_bus.space_ok;
			got.status = rsp_bus.status;
			got.tx_busy = rsp_bus.tx_busy;
			got.overrun_total = rsp_bus.overrun_total;
			got.noise_total = rsp_bus.noise_total;
			got.framing_total = rsp_bus.framing_total;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("line_valid", COUNT_W'(want.line_valid),
					COUNT_W'(got.line_valid));
				check_field("line_byte", COUNT_W'(want.line_byte), COUNT_W'(got.line_byte));
				check_field("read_byte", COUNT_W'(want.read_byte), COUNT_W'(got.read_byte));
				check_field("read_was_empty", COUNT_W'(want.read_was_empty),
					COUNT_W'(got.read_was_empty));
				check_field("space_ok", COUNT_W'(want.space_ok), COUNT_W'(got.space_ok));
				check_field("status", COUNT_W'(want.status), COUNT_W'(got.status));
				check_field("tx_busy", COUNT_W'(want.tx_busy), COUNT_W'(got.tx_busy));
				check_field("overrun_total", want.overrun_total, got.overrun_total);
				check_field("noise_total", want.noise_total, got.noise_total);
				check_field("framing_total", want.framing_total, got.framing_total);
			end
		end
	end

	// Field extremes, every function and the corner cases on short sequences
	task automatic test_directed();
		write_rx_enable(1'b1);
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_SPACE, 8'hff, 8'd127, 3'b111));
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd128, 3'b000));
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd255, 3'b000));
		// ready event while already idle
		send_item(make_cmd(FN_TXRDY, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_SEND, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_SEND, 8'hff, 8'hff, 3'b111));
		send_item(make_cmd(FN_TXRDY, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_TXRDY, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_RECV, 8'ha5, 8'd0, 3'b000));
		send_item(make_cmd(FN_RECV, 8'h11, 8'd0, 3'b100));
		send_item(make_cmd(FN_RECV, 8'h22, 8'd0, 3'b010));
		send_item(make_cmd(FN_RECV, 8'h33, 8'd0, 3'b001));
		send_item(make_cmd(FN_RECV, 8'hff, 8'd0, 3'b111));
		send_item(make_cmd(FN_READ, 8'h00, 8'd0, 3'b000));
		// read of an empty ring still moves the tail
		send_item(make_cmd(FN_READ, 8'hff, 8'hff, 3'b111));
		// tail now sits just past head: ring looks full
		send_item(make_cmd(FN_RECV, 8'h5a, 8'd0, 3'b000));
		send_item(make_cmd(FN_READ, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_READ, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_FIRST_UNUSED, 8'hff, 8'hff, 3'b111));
		send_item(make_cmd(FN_LAST_UNUSED, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FUNC_W'(FN_FIRST_UNUSED + 1'b1), 8'h81, 8'h7e, 3'b101));
		// receive disabled: events pass with no effect
		write_rx_enable(1'b0);
		send_item(make_cmd(FN_RECV, 8'h77, 8'd0, 3'b000));
		send_item(make_cmd(FN_RECV, 8'h88, 8'd0, 3'b111));
		write_rx_enable(1'b1);
	endtask

	// Fill the transmit ring until sends drop, then drain it to idle
	task automatic test_tx_ring_fill();
		logic [TX_AW-1:0] tx_nxt;
		send_item(random_cmd(FN_SEND));
		tx_nxt = tx_wr + 1'b1;
		while (tx_nxt != tx_rd) begin
			send_item(random_cmd(FN_SEND));
			tx_nxt = tx_wr + 1'b1;
		end
		repeat (2) send_item(random_cmd(FN_SEND));
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd0, 3'b000));
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd1, 3'b000));
		while (tx_wr != tx_rd) send_item(random_cmd(FN_TXRDY));
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd127, 3'b000));
		send_item(make_cmd(FN_SPACE, 8'h00, 8'd128, 3'b000));
		repeat (2) send_item(random_cmd(FN_TXRDY));
	endtask

	// Fill the receive ring past full, then read it back past empty
	task automatic test_rx_ring_fill();
		logic [RX_AW-1:0] rx_nxt;
		rx_nxt = rx_wr + 1'b1;
		while (rx_nxt != rx_rd) begin
			send_item(make_cmd(FN_RECV, BYTE_W'($urandom_range(0, 255)),
				NEED_W'($urandom_range(0, 255)), 3'b000));
			rx_nxt = rx_wr + 1'b1;
		end
		repeat (2) send_item(make_cmd(FN_RECV, BYTE_W'($urandom_range(0, 255)), 8'd0, 3'b000));
		while (rx_wr != rx_rd) send_item(random_cmd(FN_READ));
		repeat (2) send_item(random_cmd(FN_READ));
	endtask

	// Weighted mix of all functions in runs with and without idling
	task automatic mixed_traffic(int count);
		int               pick;
		uart_cmd_t        c;
		logic [TX_AW-1:0] room;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				no_stalls = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				c = random_cmd(FN_SEND);
			end else if (pick < 48) begin
				c = random_cmd(FN_TXRDY);
			end else if (pick < 73) begin
				c = random_cmd(FN_RECV);
				if ($urandom_range(0, 3) != 0)
					{c.overrun_flag, c.noise_flag, c.framing_flag} = 3'b000;
			end else if (pick < 88) begin
				c = random_cmd(FN_READ);
			end else if (pick < 97) begin
				c = random_cmd(FN_SPACE);
				// aim half of the checks at the free-slot boundary
				if ($urandom_range(0, 1) == 1) begin
					room = tx_rd - tx_wr - 1'b1;
					c.need_len = NEED_W'({1'b0, room} + $urandom_range(0, 2) - 1);
				end
			end else begin
				c = random_cmd(FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED)));
			end
			send_item(c);
		end
		no_gaps = 1'b0;
		no_stalls = 1'b0;
	endtask

	task automatic test_mixed_traffic();
		mixed_traffic(140);
		write_rx_enable(1'b0);
		mixed_traffic(40);
		write_rx_enable(1'b1);
		mixed_traffic(80);
	endtask

	// Back-to-back receive errors that bump every counter
	task automatic test_error_burst();
		no_gaps = 1'b1;
		no_stalls = 1'b1;
		repeat (20) send_item(make_cmd(FN_RECV, BYTE_W'($urandom_range(0, 255)), 8'd0, 3'b111));
		no_gaps = 1'b0;
		no_stalls = 1'b0;
		mixed_traffic(10);
	endtask

	initial begin
		cmd_bus.valid = 1'b0;
		cmd_bus.func = FN_SEND;
		cmd_bus.byte_in = '0;
		cmd_bus.need_len = '0;
		cmd_bus.overrun_flag = 1'b0;
		cmd_bus.noise_flag = 1'b0;
		cmd_bus.framing_flag = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		mismatches = 0;
		no_gaps = 1'b0;
		no_stalls = 1'b0;
		for (int i = 0; i < TX_DEPTH_DEF; i++) tx_ring[i] = '0;
		for (int i = 0; i < RX_DEPTH_DEF; i++) rx_ring[i] = '0;
		tx_wr = '0;
		tx_rd = '0;
		rx_wr = '0;
		rx_rd = '0;
		tx_active = 1'b0;
		rx_en = 1'b1;
		overrun_cnt = '0;
		noise_cnt = '0;
		framing_cnt = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_tx_ring_fill();
		test_rx_ring_fill();
		test_mixed_traffic();
		test_error_burst();
		settle_idle();

		if (mismatches == 0)
			$display("buffered_uart_ring_queues regression: pass");
		else
			$display("buffered_uart_ring_queues regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#10000000;
		$display("buffered_uart_ring_queues regression: fail");
		$finish;
	end

endmodule
